### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SACL_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SACL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition that must never hold
`define SACL_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### rtl/sacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// shared types and constants of the set-associative cache lru model
// ----------------------------------------------------------------------------
package sacl_pkg;

  // default geometry
  localparam int SACL_MAX_SETS   = 256;
  localparam int SACL_MAX_WAYS   = 8;
  localparam int SACL_ADDR_WIDTH = 64;

  // configuration register widths
  localparam int SET_BITS_W   = 4;
  localparam int BLOCK_BITS_W = 6;
  localparam int WAYS_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 4'd4;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

  // counters
  localparam int CNT_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef struct packed {
    outcome_t outcome;
    logic     hit;
    logic     evict;
  } lookup_stat_t;

endpackage

### rtl/sacl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/sacl_addr_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_addr_split
// splits a byte address into set index and tag under the current config
// ----------------------------------------------------------------------------
module sacl_addr_split
  import sacl_pkg::*;
#(
  parameter int ADDR_WIDTH = SACL_ADDR_WIDTH,
  parameter int SET_IDX_W  = 8
) (
  input  logic [ADDR_WIDTH-1:0]   address,
  input  logic [SET_BITS_W-1:0]   set_bits,
  input  logic [BLOCK_BITS_W-1:0] block_bits,
  output logic [SET_IDX_W-1:0]    set_idx,
  output logic [ADDR_WIDTH-1:0]   tag
);

  localparam logic [SET_BITS_W-1:0] SET_LIM = SET_BITS_W'(SET_IDX_W);

  logic [SET_BITS_W-1:0]   set_eff;
  logic [SET_IDX_W-1:0]    set_mask;
  logic [ADDR_WIDTH-1:0]   shifted;
  logic [BLOCK_BITS_W:0]   tag_shift;

  always_comb begin
    set_eff   = (set_bits < SET_LIM) ? set_bits : SET_LIM;
    set_mask  = ~({SET_IDX_W{1'b1}} << set_eff);
    shifted   = address >> block_bits;
    set_idx   = shifted[SET_IDX_W-1:0] & set_mask;
    // shifts of the full width or more give zero
    tag_shift = {1'b0, block_bits} + (BLOCK_BITS_W + 1)'(set_eff);
    tag       = address >> tag_shift;
  end

endmodule

### rtl/sacl_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_lookup
// tag compare, fill or victim choice and lru update for one set row
// ----------------------------------------------------------------------------
module sacl_lookup
  import sacl_pkg::*;
#(
  parameter int MAX_WAYS   = SACL_MAX_WAYS,
  parameter int ADDR_WIDTH = SACL_ADDR_WIDTH,
  localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int WAY_W     = 1 + RANK_W + ADDR_WIDTH,
  localparam int ROW_W     = MAX_WAYS * WAY_W
) (
  input  logic [ROW_W-1:0]      row_in,
  input  logic [ADDR_WIDTH-1:0] tag,
  input  logic [WAYS_W-1:0]     ways_in_use,
  output logic [ROW_W-1:0]      row_out,
  output lookup_stat_t          stat
);

  localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_WAYS - 1);
  localparam logic [WAYS_W:0]   WAYS_LIM = (WAYS_W + 1)'(MAX_WAYS);

  logic [WAYS_W:0]         ways_eff;
  logic [MAX_WAYS-1:0]     used;
  logic [MAX_WAYS-1:0]     vld;
  logic [RANK_W-1:0]       rank [MAX_WAYS];
  logic [ADDR_WIDTH-1:0]   tg   [MAX_WAYS];
  logic [MAX_WAYS-1:0]     hit_vec, empty_vec, max_vec;
  logic [MAX_WAYS-1:0]     hit_oh, fill_oh, vict_oh, target_oh;
  logic                    any_hit, any_empty, age_all;
  logic [RANK_W-1:0]       limit;
  logic [RANK_W-1:0]       rank_new;

  always_comb begin
    ways_eff = {1'b0, ways_in_use};
    if (ways_eff == '0) begin
      ways_eff = (WAYS_W + 1)'(1);
    end else if (ways_eff > WAYS_LIM) begin
      ways_eff = WAYS_LIM;
    end

    for (int i = 0; i < MAX_WAYS; i++) begin
      used[i]      = (WAYS_W + 1)'(i) < ways_eff;
      vld[i]       = row_in[i*WAY_W + WAY_W - 1];
      rank[i]      = row_in[i*WAY_W + ADDR_WIDTH +: RANK_W];
      tg[i]        = row_in[i*WAY_W +: ADDR_WIDTH];
      hit_vec[i]   = used[i] && vld[i] && (tg[i] == tag);
      empty_vec[i] = used[i] && !vld[i];
    end

    // ways holding the largest rank among the used ways
    for (int i = 0; i < MAX_WAYS; i++) begin
      max_vec[i] = used[i];
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (used[j] && (rank[j] > rank[i])) begin
          max_vec[i] = 1'b0;
        end
      end
    end

    // lowest index wins in each case
    hit_oh  = hit_vec   & (~hit_vec   + MAX_WAYS'(1));
    fill_oh = empty_vec & (~empty_vec + MAX_WAYS'(1));
    vict_oh = max_vec   & (~max_vec   + MAX_WAYS'(1));

    any_hit   = |hit_vec;
    any_empty = |empty_vec;
    age_all   = !any_hit && any_empty;

    if (any_hit) begin
      target_oh = hit_oh;
    end else if (any_empty) begin
      target_oh = fill_oh;
    end else begin
      target_oh = vict_oh;
    end

    limit = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      limit = limit | (target_oh[i] ? rank[i] : '0);
    end

    for (int i = 0; i < MAX_WAYS; i++) begin
      rank_new = rank[i];
      if (used[i] && vld[i] && (age_all || (rank[i] < limit)) && (rank[i] != RANK_TOP)) begin
        rank_new = rank[i] + RANK_W'(1);
      end
      if (target_oh[i]) begin
        row_out[i*WAY_W +: WAY_W] = {1'b1, {RANK_W{1'b0}}, tag};
      end else begin
        row_out[i*WAY_W +: WAY_W] = {vld[i], rank_new, tg[i]};
      end
    end

    stat.hit   = any_hit;
    stat.evict = !any_hit && !any_empty;
    if (any_hit) begin
      stat.outcome = OUT_HIT;
    end else if (any_empty) begin
      stat.outcome = OUT_FILL;
    end else begin
      stat.outcome = OUT_EVICT;
    end
  end

endmodule

### rtl/sacl_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_stats
// saturating hit, miss and eviction counters
// ----------------------------------------------------------------------------
module sacl_stats
  import sacl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             upd,
  input  lookup_stat_t     stat,
  input  logic             kind,
  output logic [CNT_W-1:0] hits,
  output logic [CNT_W-1:0] misses,
  output logic [CNT_W-1:0] evicts
);

  logic [CNT_W-1:0] hit_r, miss_r, evict_r;
  logic [CNT_W-1:0] hit_nxt, miss_nxt, evict_nxt;
  logic [1:0]       hit_inc;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                               input logic [1:0] inc);
    logic [CNT_W:0] s;
    s = {1'b0, v} + (CNT_W + 1)'(inc);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  always_comb begin
    // second access of a modify always hits
    hit_inc   = {1'b0, stat.hit} + {1'b0, kind};
    hit_nxt   = sat_add(hit_r, hit_inc);
    miss_nxt  = sat_add(miss_r, {1'b0, !stat.hit});
    evict_nxt = sat_add(evict_r, {1'b0, stat.evict});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= '0;
      miss_r  <= '0;
      evict_r <= '0;
    end else if (upd) begin
      hit_r   <= hit_nxt;
      miss_r  <= miss_nxt;
      evict_r <= evict_nxt;
    end
  end

  assign hits   = hit_r;
  assign misses = miss_r;
  assign evicts = evict_r;

endmodule

### rtl/set_assoc_cache_lru_sim.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// tag side of a set-associative cache with true lru replacement
// ----------------------------------------------------------------------------
// Each request carries a byte address and a kind; kind 0 is one access, kind 1
// (modify) is two accesses to the same address. The block answers every request
// with one result: the first access's outcome, whether a second access hit, and
// the saturating hit, miss and eviction totals after the request. It takes one
// request per clock while results are taken. A request is registered in the
// lookup stage at acceptance; its result loads into the result register when
// that stage moves on. The pace is set by the single pass of one set row (all
// ways' valid, rank, tag) read from the set ram, through the way logic and
// written back. A result waiting at the output still lets one more request
// into the lookup stage; after that in_ready stays low until the result is
// taken. There is no clearing pass after reset: a per-set written flag makes an
// untouched set read as all ways invalid. Configuration writes are meant for
// idle periods; lines already stored are kept across them.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim
  import sacl_pkg::*;
#(
  parameter int MAX_SETS   = SACL_MAX_SETS,
  parameter int MAX_WAYS   = SACL_MAX_WAYS,
  parameter int ADDR_WIDTH = SACL_ADDR_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [ADDR_WIDTH-1:0] in_address,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_outcome,
  output logic                  out_second_hit,
  output logic [CNT_W-1:0]      out_hits_total,
  output logic [CNT_W-1:0]      out_misses_total,
  output logic [CNT_W-1:0]      out_evictions_total
);

  // set field is clamped to the largest power of two that fits MAX_SETS
  localparam int SET_IDX_W = $clog2(MAX_SETS + 1) - 1;
  localparam int NUM_SETS  = 1 << SET_IDX_W;
  localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W     = 1 + RANK_W + ADDR_WIDTH;
  localparam int ROW_W     = MAX_WAYS * WAY_W;

  // configuration registers
  logic [SET_BITS_W-1:0]   set_bits_r;
  logic [BLOCK_BITS_W-1:0] block_bits_r;
  logic [WAYS_W-1:0]       ways_r;

  // lookup stage
  logic                    s1_vld_r;
  logic                    s1_kind_r;
  logic [SET_IDX_W-1:0]    s1_set_r;
  logic [ADDR_WIDTH-1:0]   s1_tag_r;
  logic                    s1_adv;
  logic                    in_acc;

  // address split of the incoming request
  logic [SET_IDX_W-1:0]    in_set;
  logic [ADDR_WIDTH-1:0]   in_tag;

  // set ram and bypass of the last row written
  logic [ROW_W-1:0]        ram_rdata;
  logic                    lw_vld_r;
  logic [SET_IDX_W-1:0]    lw_set_r;
  logic [ROW_W-1:0]        lw_row_r;
  logic [NUM_SETS-1:0]     row_written_r;
  logic                    lw_match;
  logic                    row_known;
  logic [ROW_W-1:0]        row_cur;
  logic [ROW_W-1:0]        row_new;
  lookup_stat_t            stat;

  // result register
  logic                    out_vld_r;
  logic                    out_vld_nxt;
  outcome_t                out_outcome_r;
  logic                    out_second_hit_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= SET_BITS_RST;
      block_bits_r <= BLOCK_BITS_RST;
      ways_r       <= WAYS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SET_BITS:   set_bits_r   <= cfg_data[SET_BITS_W-1:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_data[BLOCK_BITS_W-1:0];
        CFG_WAYS:       ways_r       <= cfg_data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  // lookup stage moves on whenever the result register is free or being taken
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  sacl_addr_split #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .SET_IDX_W  (SET_IDX_W)
  ) u_split (
    .address    (in_address),
    .set_bits   (set_bits_r),
    .block_bits (block_bits_r),
    .set_idx    (in_set),
    .tag        (in_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= in_kind;
      s1_set_r  <= in_set;
      s1_tag_r  <= in_tag;
    end
  end

  // ---------------------------------------------------------------- set ram
  // read issued at acceptance, write-back when the lookup stage moves on
  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_set_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_set_r),
    .wdata (row_new),
    .re    (in_acc),
    .raddr (in_set),
    .rdata (ram_rdata)
  );

  // the last row written is always the newest copy of its set, which covers a
  // read that happened at the same edge as that write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_vld_r      <= 1'b0;
      row_written_r <= '0;
    end else if (s1_adv) begin
      lw_vld_r                <= 1'b1;
      row_written_r[s1_set_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      lw_set_r <= s1_set_r;
      lw_row_r <= row_new;
    end
  end

  always_comb begin
    lw_match  = lw_vld_r && (lw_set_r == s1_set_r);
    row_known = row_written_r[s1_set_r];
    priority if (lw_match) begin
      row_cur = lw_row_r;
    end else if (row_known) begin
      row_cur = ram_rdata;
    end else begin
      // untouched set: all ways invalid, ranks zero
      row_cur = '0;
    end
  end

  // ---------------------------------------------------------------- way logic
  // only the first access changes the row; a modify's second access finds the
  // line just hit or filled at rank zero, so it hits and ages nothing
  sacl_lookup #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_lookup (
    .row_in      (row_cur),
    .tag         (s1_tag_r),
    .ways_in_use (ways_r),
    .row_out     (row_new),
    .stat        (stat)
  );

  // counters move with the result register, so they double as its totals
  sacl_stats u_stats (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (s1_adv),
    .stat   (stat),
    .kind   (s1_kind_r),
    .hits   (out_hits_total),
    .misses (out_misses_total),
    .evicts (out_evictions_total)
  );

  // ---------------------------------------------------------------- result
  always_comb begin
    priority if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_outcome_r    <= stat.outcome;
      out_second_hit_r <= s1_kind_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_outcome    = out_outcome_r;
  assign out_second_hit = out_second_hit_r;

  // ---------------------------------------------------------------- checks
  `SACL_ASSERT_NEVER(a_evict_le_miss, out_evictions_total > out_misses_total, "evictions exceed misses")
  `SACL_ASSERT_IMPL(a_evict_needs_row, s1_adv && stat.evict, lw_match || row_known, "eviction from a set never written")
  `SACL_ASSERT_NEXT(a_row_marked, s1_adv, lw_vld_r && row_written_r[lw_set_r], "written set not marked")

endmodule
